// ===== rtl/pq_reply_frame_checker_assert.svh =====
// Assertion macros used by the reply frame checker top level.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PQ_REPLY_FRAME_CHECKER_ASSERT_SVH
`define PQ_REPLY_FRAME_CHECKER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define PQRF_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("pq_reply_frame_checker assertion failed");

// The condition must hold in the cycle after the trigger.
`define PQRF_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("pq_reply_frame_checker assertion failed");

`endif

// ===== rtl/pqrf_pkg.sv =====
// ----------------------------------------------------------------------------
// pqrf_pkg
// Types and constants shared by the reply frame checker modules.
// ----------------------------------------------------------------------------
package pqrf_pkg;

  // Frame layout constants.
  localparam logic [31:0] PQ_CONSTRUCTOR    = 32'h0516_2463;
  localparam logic [7:0]  LONG_HEADER       = 8'h7f;
  localparam int unsigned MIN_PAYLOAD_WORDS = 6;   // 24 bytes
  localparam int unsigned BODY_HEADER       = 20;
  localparam int unsigned LEN_OFFSET        = 16;
  localparam int unsigned CTOR_OFFSET       = 20;
  localparam int unsigned NONCE_OFFSET      = 24;
  localparam int unsigned NONCE_BYTES       = 16;

  // Payload length in bytes: 24-bit word count times four.
  localparam int unsigned LEN_W = 26;

  // Configuration register indexes.
  localparam logic REG_NONCE_LOW  = 1'b0;
  localparam logic REG_NONCE_HIGH = 1'b1;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  // One received request.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       first_of_reply;
  } item_t;

  // Verdict from the parser for one byte.
  typedef struct packed {
    logic        emit;
    logic        status;
    logic [23:0] frame_words;
  } result_t;

endpackage

// ===== rtl/pqrf_in_stage.sv =====
// ----------------------------------------------------------------------------
// pqrf_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module pqrf_in_stage
  import pqrf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  // Stall only while a held byte cannot move on.
  assign in_stall = item_valid && !advance;

  // Valid flag of the held byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  // Payload of the held byte.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/pqrf_parser.sv =====
// ----------------------------------------------------------------------------
// pqrf_parser
// Frame parser: decodes the header, scans the payload and forms the verdict.
// ----------------------------------------------------------------------------
module pqrf_parser
  import pqrf_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  item_t       item,
  input  logic [63:0] nonce_low,
  input  logic [63:0] nonce_high,
  output result_t     res
);

  localparam int unsigned OFF_W = $clog2(MAX_FRAME_BYTES);

  phase_t             phase, phase_next;
  logic [1:0]         lbs, lbs_next;
  logic [23:0]        pw, pw_next;
  logic [OFF_W-1:0]   off, off_next;
  logic [31:0]        bl, bl_next;
  logic [31:0]        ctor, ctor_next;
  logic               mm, mm_next;

  phase_t             eff_phase;
  logic [7:0]         b;
  logic [23:0]        pw_merged;
  logic [23:0]        hdr_words;
  logic [26:0]        hdr_bytes;
  logic               hdr_bad;
  logic               len_last;
  logic [LEN_W-1:0]   pay_len;
  logic [OFF_W:0]     off_inc;
  logic               in_len, in_ctor, in_nonce;
  logic [3:0]         nidx;
  logic [63:0]        nword;
  logic [7:0]         nbyte;
  logic [31:0]        bl_ins, ctor_ins;
  logic               mm_ins;
  logic               pay_last, pay_bad;

  // A first byte of a reply always restarts at the header.
  assign b         = item.rx_byte;
  assign eff_phase = item.first_of_reply ? PH_HEADER : phase;

  // Merge one byte of the extended word count.
  always_comb begin
    pw_merged = pw;
    case (lbs)
      2'd0:    pw_merged[7:0]   = b;
      2'd1:    pw_merged[15:8]  = b;
      2'd2:    pw_merged[23:16] = b;
      default: pw_merged        = pw;
    endcase
  end

  assign len_last  = (lbs == 2'd2);

  // Header checks on the completed word count.
  assign hdr_words = (eff_phase == PH_HEADER) ? {16'd0, b} : pw_merged;
  assign hdr_bytes = (eff_phase == PH_HEADER) ? 27'd1 : 27'd4;
  assign hdr_bad   = (hdr_words == 24'd0) ||
                     ((hdr_bytes + {1'b0, hdr_words, 2'b00}) > 27'(MAX_FRAME_BYTES)) ||
                     (hdr_words < 24'(MIN_PAYLOAD_WORDS));

  // Payload field locations.
  assign pay_len  = {pw, 2'b00};
  assign off_inc  = {1'b0, off} + (OFF_W+1)'(1);
  assign pay_last = (LEN_W'(off_inc) == pay_len);
  assign in_len   = (off >= OFF_W'(LEN_OFFSET)) && (off < OFF_W'(CTOR_OFFSET));
  assign in_ctor  = (off >= OFF_W'(CTOR_OFFSET)) && (off < OFF_W'(NONCE_OFFSET));
  assign in_nonce = (off >= OFF_W'(NONCE_OFFSET)) &&
                    (off < OFF_W'(NONCE_OFFSET + NONCE_BYTES));

  // Expected nonce byte; offsets 24 to 39 map to nonce bytes 0 to 15.
  assign nidx  = {~off[3], off[2:0]};
  assign nword = nidx[3] ? nonce_high : nonce_low;
  assign nbyte = nword[{nidx[2:0], 3'b000} +: 8];

  assign bl_ins   = in_len  ? (bl   | (32'(b) << {off[1:0], 3'b000})) : bl;
  assign ctor_ins = in_ctor ? (ctor | (32'(b) << {off[1:0], 3'b000})) : ctor;
  assign mm_ins   = mm || (in_nonce && (b != nbyte));

  // The body length is complete before the earliest possible last byte.
  assign pay_bad = (bl < 32'(BODY_HEADER)) ||
                   ((33'(BODY_HEADER) + {1'b0, bl}) > 33'(pay_len)) ||
                   (ctor_ins != PQ_CONSTRUCTOR) || mm_ins;

  // Next-state logic.
  always_comb begin
    phase_next = phase;
    lbs_next   = lbs;
    pw_next    = pw;
    off_next   = off;
    bl_next    = bl;
    ctor_next  = ctor;
    mm_next    = mm;
    case (eff_phase)
      PH_HEADER: begin
        if (b == LONG_HEADER) begin
          pw_next    = 24'd0;
          lbs_next   = 2'd0;
          phase_next = PH_LENGTH;
        end else begin
          pw_next    = hdr_words;
          off_next   = '0;
          bl_next    = '0;
          ctor_next  = '0;
          mm_next    = 1'b0;
          phase_next = hdr_bad ? PH_DONE : PH_PAYLOAD;
        end
      end
      PH_LENGTH: begin
        pw_next = pw_merged;
        if (len_last) begin
          lbs_next   = 2'd0;
          off_next   = '0;
          bl_next    = '0;
          ctor_next  = '0;
          mm_next    = 1'b0;
          phase_next = hdr_bad ? PH_DONE : PH_PAYLOAD;
        end else begin
          lbs_next = lbs + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        bl_next   = bl_ins;
        ctor_next = ctor_ins;
        mm_next   = mm_ins;
        if (pay_last) begin
          phase_next = PH_DONE;
        end else begin
          off_next = off_inc[OFF_W-1:0];
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  // Verdict outputs.
  always_comb begin
    res.emit        = 1'b0;
    res.status      = 1'b0;
    res.frame_words = pw;
    case (eff_phase)
      PH_HEADER: begin
        res.emit        = (b != LONG_HEADER) && hdr_bad;
        res.status      = 1'b1;
        res.frame_words = hdr_words;
      end
      PH_LENGTH: begin
        res.emit        = len_last && hdr_bad;
        res.status      = 1'b1;
        res.frame_words = hdr_words;
      end
      PH_PAYLOAD: begin
        res.emit   = pay_last;
        res.status = pay_bad;
      end
      default: begin
        res.emit = 1'b0;
      end
    endcase
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      lbs   <= 2'd0;
      pw    <= 24'd0;
      off   <= '0;
      bl    <= 32'd0;
      ctor  <= 32'd0;
      mm    <= 1'b0;
    end else if (advance) begin
      phase <= phase_next;
      lbs   <= lbs_next;
      pw    <= pw_next;
      off   <= off_next;
      bl    <= bl_next;
      ctor  <= ctor_next;
      mm    <= mm_next;
    end
  end

endmodule

// ===== rtl/pqrf_out_stage.sv =====
// ----------------------------------------------------------------------------
// pqrf_out_stage
// Result register: holds one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module pqrf_out_stage
  import pqrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  output logic        res_free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [23:0] frame_words
);

  // The register can take a new verdict when empty or being emptied.
  assign res_free = !out_valid || !out_stall;

  // Valid flag of the held verdict.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= load;
    end
  end

  // Verdict payload.
  always_ff @(posedge clk) begin
    if (res_free && load) begin
      status      <= res.status;
      frame_words <= res.frame_words;
    end
  end

endmodule

// ===== rtl/pq_reply_frame_checker.sv =====
// ----------------------------------------------------------------------------
// pq_reply_frame_checker
// Checks one length-prefixed reply frame per reply, one byte per request.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake           Payload
//   in        receive    in_valid/in_stall   rx_byte, first_of_reply
//   out       send       out_valid/out_stall status, frame_words
//   cfg       receive    cfg_write           cfg_index, cfg_data
//
// One byte is taken every cycle while the result register is free. A verdict
// passes the input register, which holds its byte, and then the result register,
// which the parser loads as soon as that register is free.
// Reset clears the parser to wait for a header and zeroes the nonce.
// in_stall rises only while a verdict is held in the result register under
// out_stall and a byte is waiting in the input register.
// ----------------------------------------------------------------------------
`include "pq_reply_frame_checker_assert.svh"

module pq_reply_frame_checker
  import pqrf_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        first_of_reply,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [23:0] frame_words,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  item_t       in_item;
  item_t       item;
  logic        item_valid;
  logic        advance;
  logic        res_free;
  result_t     pres;
  logic [63:0] nonce_low;
  logic [63:0] nonce_high;

  assign in_item.rx_byte        = rx_byte;
  assign in_item.first_of_reply = first_of_reply;

  // The held byte moves on whenever the result register has room.
  assign advance = item_valid && res_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      nonce_low  <= 64'd0;
      nonce_high <= 64'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NONCE_LOW:  nonce_low  <= cfg_data;
        REG_NONCE_HIGH: nonce_high <= cfg_data;
        default:        nonce_low  <= nonce_low;
      endcase
    end
  end

  pqrf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  pqrf_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (item),
    .nonce_low  (nonce_low),
    .nonce_high (nonce_high),
    .res        (pres)
  );

  pqrf_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && pres.emit),
    .res         (pres),
    .res_free    (res_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .frame_words (frame_words)
  );

  // Input backpressure comes only from a blocked result register.
  `PQRF_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
  // A verdict produced by an advancing byte is presented next cycle.
  `PQRF_ASSERT_NEXT(a_verdict_shown, advance && pres.emit, out_valid)
  // A taken verdict is not shown again unless a new one was produced.
  `PQRF_ASSERT_NEXT(a_no_repeat, out_valid && !out_stall && !(advance && pres.emit),
                    !out_valid)

endmodule
